/* design/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Field widths, request and slot mark codes, and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int SLOTS_DEF = 256;

	localparam int TYPE_W = 2;
	localparam int KEY_W  = 64;
	localparam int HASH_W = 64;
	localparam int VAL_W  = 64;
	localparam int LIM_W  = 9;
	localparam int LIVE_W = 9;

	localparam logic [LIM_W-1:0] LIMIT_RESET = 9'd192;

	// Hash bits folded into the slot index per cycle when the table size is not
	// a power of two.
	localparam int HMOD_BITS = 8;

	typedef enum logic [TYPE_W-1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_DELETE = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_LIVE  = 2'd1,
		MARK_TOMB  = 2'd2
	} mark_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic idle;
		logic hash_run;
		logic probe_first;
		logic probe_step;
		logic commit;
		logic sweep;
		logic deliver;
	} lpht_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic accept;
		logic acc_clear;
		logic hash_done;
		logic probe_stop;
		logic sweep_last;
		logic out_free;
	} lpht_stat_t;

endpackage

/* design/lpht_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid and ready handshake carrying one table request.
// ----------------------------------------------------------------------------
interface lpht_req_if;
	import lpht_pkg::*;

	logic              valid;
	logic              ready;
	logic [TYPE_W-1:0] req_type;
	logic [KEY_W-1:0]  key;
	logic [HASH_W-1:0] key_hash;
	logic [VAL_W-1:0]  value;

	modport source (output valid, output req_type, output key, output key_hash,
		output value, input ready);
	modport sink (input valid, input req_type, input key, input key_hash,
		input value, output ready);

endinterface

/* design/lpht_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid and ready handshake carrying the result of one table request.
// ----------------------------------------------------------------------------
interface lpht_rsp_if;
	import lpht_pkg::*;

	logic              valid;
	logic              ready;
	logic              status;
	logic              found;
	logic [VAL_W-1:0]  read_value;
	logic [LIVE_W-1:0] live_count;

	modport source (output valid, output status, output found, output read_value,
		output live_count, input ready);
	modport sink (input valid, input status, input found, input read_value,
		input live_count, output ready);

endinterface

/* design/lpht_hmod.sv */
// ----------------------------------------------------------------------------
// Start slot reduction
// Reduces the request hash modulo the slot count. A power-of-two table takes
// the low bits at once; otherwise eight hash bits are folded in per cycle.
// ----------------------------------------------------------------------------
module lpht_hmod #(
	parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lpht_pkg::HASH_W-1:0]    hash,
	input  logic                           run,
	output logic [$clog2(SLOTS)-1:0]       idx,
	output logic                           done
);
	import lpht_pkg::*;

	localparam int  IDX_W    = $clog2(SLOTS);
	localparam bit  IS_POW2  = (SLOTS & (SLOTS - 1)) == 0;
	localparam int  HMOD_CYC = IS_POW2 ? 0 : HASH_W / HMOD_BITS;
	localparam logic [IDX_W:0] SLOTS_X = (IDX_W + 1)'(SLOTS);

	logic [3:0]        cnt_q;
	logic [IDX_W-1:0]  r_q;
	logic [HASH_W-1:0] sh_q;
	logic [IDX_W-1:0]  r_nxt;

	assign done = cnt_q == 4'(HMOD_CYC);
	assign idx  = r_q;

	// Restoring reduction, one hash bit per step, most significant bit first.
	always_comb begin
		logic [IDX_W:0] acc;
		acc = {1'b0, r_q};
		for (int i = 0; i < HMOD_BITS; i++) begin
			acc = {acc[IDX_W-1:0], sh_q[HASH_W-1-i]};
			if (acc >= SLOTS_X) begin
				acc = acc - SLOTS_X;
			end
		end
		r_nxt = acc[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (run && !done) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q  <= IS_POW2 ? hash[IDX_W-1:0] : '0;
			sh_q <= hash;
		end else if (run && !done) begin
			r_q  <= r_nxt;
			sh_q <= {sh_q[HASH_W-HMOD_BITS-1:0], {HMOD_BITS{1'b0}}};
		end
	end

endmodule

/* design/lpht_ctrl.sv */
// ----------------------------------------------------------------------------
// Hash table controller
// Sequences the slot sweep after reset and on clear, and the start slot
// reduction, probe walk, commit and response hand-over for each other request.
// ----------------------------------------------------------------------------
module lpht_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lpht_pkg::lpht_stat_t stat,
	output lpht_pkg::lpht_cmd_t  cmd
);
	import lpht_pkg::*;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_COMMIT,
		ST_CLEAR,
		ST_DONE
	} state_t;

	state_t state_q;

	always_comb begin
		cmd             = '0;
		cmd.idle        = state_q == ST_IDLE;
		cmd.hash_run    = state_q == ST_HASH;
		cmd.probe_first = (state_q == ST_HASH) && stat.hash_done;
		cmd.probe_step  = state_q == ST_PROBE;
		cmd.commit      = state_q == ST_COMMIT;
		cmd.sweep       = (state_q == ST_SWEEP) || (state_q == ST_CLEAR);
		cmd.deliver     = (state_q == ST_DONE) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					if (stat.sweep_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (stat.accept) state_q <= stat.acc_clear ? ST_CLEAR : ST_HASH;
				end
				ST_HASH: begin
					if (stat.hash_done) state_q <= ST_PROBE;
				end
				ST_PROBE: begin
					if (stat.probe_stop) state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_DONE;
				end
				ST_CLEAR: begin
					if (stat.sweep_last) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_SWEEP;
				end
			endcase
		end
	end

endmodule

/* design/lpht_dp.sv */
// ----------------------------------------------------------------------------
// Hash table datapath
// Slot memories, probe walk registers, live count, load limit register and
// the response output register.
// ----------------------------------------------------------------------------
module lpht_dp #(
	parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lpht_pkg::lpht_cmd_t          cmd,
	output lpht_pkg::lpht_stat_t         stat,
	lpht_req_if.sink                     req,
	lpht_rsp_if.source                   rsp,
	input  logic                         cfg_we,
	input  logic [lpht_pkg::LIM_W-1:0]   cfg_wdata
);
	import lpht_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	// Slot stores; the mark store is swept to empty after reset and on clear.
	logic [KEY_W-1:0]  key_mem  [SLOTS];
	logic [HASH_W-1:0] hash_mem [SLOTS];
	logic [VAL_W-1:0]  val_mem  [SLOTS];
	mark_t             mark_mem [SLOTS];

	req_t              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [HASH_W-1:0] hash_q;
	logic [VAL_W-1:0]  val_q;
	logic              accept;

	logic [IDX_W-1:0]  start_idx;
	logic              hash_done;

	logic [IDX_W-1:0]  rd_addr;
	logic [KEY_W-1:0]  rd_key_q;
	logic [HASH_W-1:0] rd_hash_q;
	logic [VAL_W-1:0]  rd_val_q;
	mark_t             rd_mark_q;

	logic [IDX_W-1:0]  cur_q;
	logic [IDX_W-1:0]  cur_nxt;
	logic [IDX_W-1:0]  n_q;
	logic [IDX_W-1:0]  tomb_q;
	logic              have_tomb_q;
	logic [IDX_W-1:0]  where_q;
	logic              hit_q;
	logic              ok_q;
	logic [VAL_W-1:0]  hit_val_q;

	logic              is_empty;
	logic              is_tomb;
	logic              is_match;
	logic              tomb_any;
	logic [IDX_W-1:0]  where_c;

	logic [IDX_W-1:0]  sweep_q;
	logic              sweep_last;

	logic [CNT_W-1:0]  occ_q;
	logic [LIM_W-1:0]  limit_q;
	logic              full;

	logic              kh_we;
	logic              val_we;
	logic              mark_we;
	logic [IDX_W-1:0]  mark_addr;
	mark_t             mark_wdata;
	logic              occ_inc;
	logic              occ_dec;
	logic              status_c;
	logic              found_c;
	logic [VAL_W-1:0]  rd_c;

	logic              res_status_q;
	logic              res_found_q;
	logic [VAL_W-1:0]  res_rd_q;
	logic              out_valid_q;

	// Request intake.
	assign req.ready = cmd.idle;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req_t'(req.req_type);
			key_q  <= req.key;
			hash_q <= req.key_hash;
			val_q  <= req.value;
		end
	end

	lpht_hmod #(.SLOTS(SLOTS)) u_hmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.hash   (req.key_hash),
		.run    (cmd.hash_run),
		.idx    (start_idx),
		.done   (hash_done)
	);

	// Slot reads run one ahead of the probe: the next slot is fetched, or the start slot when the walk begins.
	assign cur_nxt = (cur_q == LAST_IDX) ? '0 : IDX_W'(cur_q + 1'b1);
	assign rd_addr = cmd.probe_first ? start_idx : cur_nxt;

	always_ff @(posedge clk) begin
		if (kh_we) begin
			key_mem[where_q]  <= key_q;
			hash_mem[where_q] <= hash_q;
		end
		if (val_we) begin
			val_mem[where_q] <= val_q;
		end
		rd_key_q  <= key_mem[rd_addr];
		rd_hash_q <= hash_mem[rd_addr];
		rd_val_q  <= val_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_addr] <= mark_wdata;
		end
		rd_mark_q <= mark_mem[rd_addr];
	end

	// Probe evaluation of the slot whose data has just arrived.
	assign is_empty = rd_mark_q == MARK_EMPTY;
	assign is_tomb  = rd_mark_q == MARK_TOMB;
	assign is_match = (rd_mark_q == MARK_LIVE) && (rd_hash_q == hash_q) &&
		(rd_key_q == key_q);
	assign tomb_any = have_tomb_q || is_tomb;
	assign where_c  = is_match ? cur_q : (have_tomb_q ? tomb_q : cur_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			n_q         <= '0;
			tomb_q      <= '0;
			have_tomb_q <= 1'b0;
		end else if (cmd.probe_first) begin
			cur_q       <= start_idx;
			n_q         <= '0;
			have_tomb_q <= 1'b0;
		end else if (cmd.probe_step) begin
			cur_q <= cur_nxt;
			n_q   <= IDX_W'(n_q + 1'b1);
			if (is_tomb && !have_tomb_q) begin
				tomb_q      <= cur_q;
				have_tomb_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.probe_step) begin
			where_q   <= where_c;
			hit_q     <= is_match;
			ok_q      <= is_empty || is_match || tomb_any;
			hit_val_q <= rd_val_q;
		end
	end

	// Mark sweep counter; it ends every pass back at slot zero.
	assign sweep_last = sweep_q == LAST_IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= sweep_last ? '0 : IDX_W'(sweep_q + 1'b1);
		end
	end

	// Load limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	assign full = CMP_W'(occ_q) >= CMP_W'(limit_q);

	// Commit decision and slot writes.
	always_comb begin
		kh_we      = 1'b0;
		val_we     = 1'b0;
		mark_we    = cmd.sweep;
		mark_addr  = cmd.sweep ? sweep_q : where_q;
		mark_wdata = MARK_EMPTY;
		occ_inc    = 1'b0;
		occ_dec    = 1'b0;
		status_c   = 1'b0;
		found_c    = 1'b0;
		rd_c       = '0;
		if (cmd.commit) begin
			case (op_q)
				REQ_LOOKUP: begin
					found_c = hit_q;
					rd_c    = hit_q ? hit_val_q : '0;
				end
				REQ_INSERT: begin
					if (hit_q) begin
						found_c = 1'b1;
						val_we  = 1'b1;
					end else if (!ok_q || full) begin
						status_c = 1'b1;
					end else begin
						kh_we      = 1'b1;
						val_we     = 1'b1;
						mark_we    = 1'b1;
						mark_wdata = MARK_LIVE;
						occ_inc    = 1'b1;
					end
				end
				REQ_DELETE: begin
					if (hit_q) begin
						found_c    = 1'b1;
						mark_we    = 1'b1;
						mark_wdata = MARK_TOMB;
						occ_dec    = 1'b1;
					end
				end
				default: begin
					found_c = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (accept && (req.req_type == REQ_CLEAR)) begin
			occ_q <= '0;
		end else if (occ_inc) begin
			occ_q <= CNT_W'(occ_q + 1'b1);
		end else if (occ_dec) begin
			occ_q <= CNT_W'(occ_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_status_q <= 1'b0;
			res_found_q  <= 1'b0;
			res_rd_q     <= '0;
		end else if (cmd.commit) begin
			res_status_q <= status_c;
			res_found_q  <= found_c;
			res_rd_q     <= rd_c;
		end
	end

	// Response output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deliver) begin
			rsp.status     <= res_status_q;
			rsp.found      <= res_found_q;
			rsp.read_value <= res_rd_q;
			rsp.live_count <= LIVE_W'(occ_q);
		end
	end

	assign rsp.valid = out_valid_q;

	always_comb begin
		stat            = '0;
		stat.accept     = accept;
		stat.acc_clear  = req.req_type == REQ_CLEAR;
		stat.hash_done  = hash_done;
		stat.probe_stop = is_empty || is_match || (n_q == LAST_IDX);
		stat.sweep_last = sweep_last;
		stat.out_free   = !out_valid_q || rsp.ready;
	end

endmodule

/* design/linear_probe_hash_table_unit.sv */
// ----------------------------------------------------------------------------
// Linear probe hash table unit
// Open-addressing table with linear probing and tombstones, one request at a
// time, with a controller sequencing a datapath of slot memories.
// ----------------------------------------------------------------------------
// A request's response follows its walk, one slot per cycle through the single
//   read port; sizes that are not a power of two first reduce the 64-bit hash to
//   a start slot. A new request is taken only after the last response has been
//   handed to the output register. After reset the slot marks are swept to empty,
//   one slot per cycle, with requests held off meanwhile; clear sweeps them too.
module linear_probe_hash_table_unit #(
	parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lpht_req_if.sink                   req,
	lpht_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [lpht_pkg::LIM_W-1:0] cfg_wdata
);
	import lpht_pkg::*;

	lpht_cmd_t  cmd;
	lpht_stat_t stat;

	// The controller owns the sequence of each request: start slot reduction,
	// the walk, the commit of slot writes and the hand-over of the response.
	lpht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// The datapath holds the slot stores, the walk registers, the live count,
	// the load limit and the response register that decouples the output side.
	lpht_dp #(.SLOTS(SLOTS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Apart from probe_first with hash_run, no two commands come in one cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.idle, cmd.hash_run, cmd.probe_step, cmd.commit, cmd.sweep,
			cmd.deliver}))
		else $error("controller issued overlapping datapath commands");

	// Once a request is taken, no further request is taken until it is done.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.accept |=> !req.ready)
		else $error("request taken while another is in progress");

	// A response is only loaded when the output register is free or draining,
	// so no earlier response can be overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deliver |-> (!rsp.valid || rsp.ready))
		else $error("response overwritten before it was taken");

endmodule
